### rtl/lnw_pkg.sv
// ----------------------------------------------------------------------------
// lnw_pkg
// Shared types and codes for the last-N window buffer: item layouts,
// function codes and the step flags that the front hands to the back.
// ----------------------------------------------------------------------------
package lnw_pkg;

    // Function codes of an input item
    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_DUMP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_SETLEN = 2'd3;

    // Tag codes
    localparam logic [1:0] TAG_INT  = 2'd0;
    localparam logic [1:0] TAG_RSVD = 2'd3;

    // Window length after reset
    localparam int RESET_LENGTH = 12;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  item_tag;
        logic [31:0] item_value;
        logic [7:0]  new_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_tag;
        logic [31:0] out_value;
        logic        out_last;
    } t_out_item;

    // One window store entry
    typedef struct packed {
        logic [1:0]  tag;
        logic [31:0] value;
    } t_entry;

    // Per-step behaviour of a back-end sweep
    typedef struct packed {
        logic wr;        // write the step's data back to the store
        logic emit;      // send the step's data out as a result
        logic new_last;  // last step takes the command's data, not the store
        logic new_all;   // every step takes the command's data
    } t_op_flags;

    typedef struct packed {
        logic run;   // a sweep is in progress
        logic init;  // clearing pass after reset
    } t_back_stat;

    localparam t_op_flags OPF_APPEND    = '{wr: 1'b1, emit: 1'b0, new_last: 1'b1, new_all: 1'b0};
    localparam t_op_flags OPF_FILL_EMIT = '{wr: 1'b1, emit: 1'b1, new_last: 1'b1, new_all: 1'b0};
    localparam t_op_flags OPF_SHIFT     = '{wr: 1'b1, emit: 1'b1, new_last: 1'b1, new_all: 1'b0};
    localparam t_op_flags OPF_DUMP      = '{wr: 1'b0, emit: 1'b1, new_last: 1'b0, new_all: 1'b0};
    localparam t_op_flags OPF_CLEAR     = '{wr: 1'b1, emit: 1'b0, new_last: 1'b0, new_all: 1'b1};
    localparam t_op_flags OPF_COPY      = '{wr: 1'b1, emit: 1'b0, new_last: 1'b0, new_all: 1'b0};

endpackage

### rtl/lnw_front.sv
// ----------------------------------------------------------------------------
// lnw_front
// Accepts items, tracks fill count and window length, and turns each item
// that needs one into a store sweep command for the back end.
// ----------------------------------------------------------------------------
module lnw_front import lnw_pkg::*; #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH),
    localparam int LW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  t_in_item      i_item,
    output logic          o_cmd_vld,
    output t_op_flags     o_cmd_flags,
    output logic [AW-1:0] o_cmd_k0,
    output logic [AW-1:0] o_cmd_k1,
    output logic [AW-1:0] o_cmd_off,
    output t_entry        o_cmd_data
);

    localparam int          RST_LEN = (RESET_LENGTH < DEPTH) ? RESET_LENGTH : DEPTH;
    localparam logic [8:0]  DEPTH9  = 9'(DEPTH);

    logic [LW-1:0] r_fill, n_fill;
    logic [LW-1:0] r_len,  n_len;
    logic [1:0]    push_tag;
    logic [8:0]    len9;
    logic          len_ok;
    logic [LW-1:0] len_req;
    logic [LW-1:0] fill_inc;

    always_comb begin
        push_tag    = (i_item.item_tag == TAG_RSVD) ? TAG_INT : i_item.item_tag;
        len9        = {1'b0, i_item.new_length};
        len_ok      = (len9 != 9'd0) && (len9 <= DEPTH9);
        len_req     = LW'(len9);
        fill_inc    = r_fill + LW'(1);
        n_fill      = r_fill;
        n_len       = r_len;
        o_cmd_vld   = 1'b0;
        o_cmd_flags = OPF_DUMP;
        o_cmd_k0    = '0;
        o_cmd_k1    = AW'(r_len - LW'(1));
        o_cmd_off   = '0;
        o_cmd_data  = '{tag: push_tag, value: i_item.item_value};
        if (i_accept) begin
            case (i_item.func)
                FUNC_PUSH: begin
                    o_cmd_vld = 1'b1;
                    if (r_fill < r_len) begin
                        n_fill = fill_inc;
                        if (fill_inc == r_len) begin
                            o_cmd_flags = OPF_FILL_EMIT;
                        end else begin
                            // single step at the fill position
                            o_cmd_flags = OPF_APPEND;
                            o_cmd_k0    = AW'(r_fill);
                            o_cmd_k1    = AW'(r_fill);
                        end
                    end else begin
                        o_cmd_flags = OPF_SHIFT;
                        o_cmd_off   = AW'(1);
                    end
                end
                FUNC_DUMP: begin
                    o_cmd_vld = 1'b1;
                end
                FUNC_CLEAR: begin
                    o_cmd_vld   = 1'b1;
                    o_cmd_flags = OPF_CLEAR;
                    o_cmd_k1    = AW'(DEPTH - 1);
                    o_cmd_data  = '0;
                    n_fill      = '0;
                end
                FUNC_SETLEN: begin
                    if (len_ok) begin
                        n_len = len_req;
                        if (len_req < r_fill) begin
                            // keep the newest entries: move them to the front
                            o_cmd_vld   = 1'b1;
                            o_cmd_flags = OPF_COPY;
                            o_cmd_k1    = AW'(len_req - LW'(1));
                            o_cmd_off   = AW'(r_fill - len_req);
                            n_fill      = len_req;
                        end
                    end
                end
                default: begin
                    o_cmd_vld = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len  <= LW'(RST_LEN);
        end else begin
            r_fill <= n_fill;
            r_len  <= n_len;
        end
    end

endmodule

### rtl/lnw_queue.sv
// ----------------------------------------------------------------------------
// lnw_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module lnw_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_vld,
    output logic         o_full,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_slot [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         do_push, do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign o_vld   = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

### rtl/lnw_back.sv
// ----------------------------------------------------------------------------
// lnw_back
// Window store and sweep sequencer: during a sweep one store entry per cycle
// is read, optionally replaced, and optionally written back and emitted.
// ----------------------------------------------------------------------------
module lnw_back import lnw_pkg::*; #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_vld,
    input  t_op_flags     i_cmd_flags,
    input  logic [AW-1:0] i_cmd_k0,
    input  logic [AW-1:0] i_cmd_k1,
    input  logic [AW-1:0] i_cmd_off,
    input  t_entry        i_cmd_data,
    output logic          o_pop,
    output t_back_stat    o_stat,
    output logic          o_valid,
    output t_out_item     o_result
);

    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    t_entry        r_mem [DEPTH];
    t_entry        r_rdata;

    logic          r_run, r_init;
    logic [AW-1:0] r_k, r_end, r_off;
    t_op_flags     r_flags;
    t_entry        r_new;

    logic          r_s2_vld, r_s2_wr, r_s2_emit, r_s2_sel, r_s2_last;
    logic [AW-1:0] r_s2_k;
    t_entry        r_s2_new;

    logic          r_out_vld;
    t_out_item     r_out;

    logic          step_last, step_sel;
    logic [AW:0]   rsum;
    logic [AW-1:0] raddr;
    t_entry        s2_data;

    assign o_pop  = i_cmd_vld && !r_run;
    assign o_stat = '{run: r_run, init: r_init};

    always_comb begin
        step_last = (r_k == r_end);
        step_sel  = r_flags.new_all || (r_flags.new_last && step_last);
        rsum      = {1'b0, r_k} + {1'b0, r_off};
        // keep the address inside the store; such reads are never used
        raddr     = (rsum < DEPTH_W) ? rsum[AW-1:0] : '0;
        s2_data   = r_s2_sel ? r_s2_new : r_rdata;
    end

    // store: one read and one write port, read data registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[raddr];
        if (r_s2_vld && r_s2_wr) begin
            r_mem[r_s2_k] <= s2_data;
        end
    end

    // issue stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b1;
            r_init  <= 1'b1;
            r_k     <= '0;
            r_end   <= AW'(DEPTH - 1);
            r_off   <= '0;
            r_flags <= OPF_CLEAR;
            r_new   <= '0;
        end else if (r_run) begin
            if (step_last) begin
                r_run  <= 1'b0;
                r_init <= 1'b0;
            end else begin
                r_k <= r_k + AW'(1);
            end
        end else if (i_cmd_vld) begin
            r_run   <= 1'b1;
            r_k     <= i_cmd_k0;
            r_end   <= i_cmd_k1;
            r_off   <= i_cmd_off;
            r_flags <= i_cmd_flags;
            r_new   <= i_cmd_data;
        end
    end

    // write-back / emit stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s2_vld  <= r_run;
            r_out_vld <= r_s2_vld && r_s2_emit;
        end
        r_s2_k    <= r_k;
        r_s2_wr   <= r_flags.wr;
        r_s2_emit <= r_flags.emit;
        r_s2_sel  <= step_sel;
        r_s2_last <= step_last;
        r_s2_new  <= r_new;
        r_out     <= '{out_tag: s2_data.tag, out_value: s2_data.value, out_last: r_s2_last};
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

### rtl/last_n_window_buffer_unit.sv
// ----------------------------------------------------------------------------
// last_n_window_buffer_unit
// Keeps the last N tagged items and emits the window, oldest first, on
// each push that fills or shifts it and on each dump.
// ----------------------------------------------------------------------------
// Items enter on start while busy is low; the front updates the fill count
// and window length at once and queues a store sweep (two commands deep).
// The back end runs each sweep over the window memory, which has one read
// and one write port, at one entry per cycle; a push that fills or shifts
// the window, and a dump, sweep the whole window, and their results come out
// back to back, one per cycle, with out_last on the final one. A push into
// a filling window is a one-step sweep, a clear a DEPTH-step sweep, a shrink
// below the fill count one step per kept entry, and other length changes
// need no sweep; the back end takes each command from the queue only
// between sweeps. The receiver cannot stall: every o_valid cycle is a
// result that must be taken. After reset busy stays high while a clearing
// pass zeroes the store.
module last_n_window_buffer_unit import lnw_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int QW = $bits(t_op_flags) + 3 * AW + $bits(t_entry);

    logic          accept;
    logic          f_vld;
    t_op_flags     f_flags;
    logic [AW-1:0] f_k0, f_k1, f_off;
    t_entry        f_data;

    logic          q_vld, q_full, q_pop;
    logic [QW-1:0] q_data;

    t_op_flags     d_flags;
    logic [AW-1:0] d_k0, d_k1, d_off;
    t_entry        d_data;

    t_back_stat    b_stat;

    // hold off new items while the queue is full or the store is clearing
    assign busy   = !i_rst_n || q_full || b_stat.init;
    assign accept = start && !busy;

    lnw_front #(.DEPTH(DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd_vld   (f_vld),
        .o_cmd_flags (f_flags),
        .o_cmd_k0    (f_k0),
        .o_cmd_k1    (f_k1),
        .o_cmd_off   (f_off),
        .o_cmd_data  (f_data)
    );

    lnw_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_data  ({f_flags, f_k0, f_k1, f_off, f_data}),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    assign {d_flags, d_k0, d_k1, d_off, d_data} = q_data;

    lnw_back #(.DEPTH(DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (q_vld),
        .i_cmd_flags (d_flags),
        .i_cmd_k0    (d_k0),
        .i_cmd_k1    (d_k1),
        .i_cmd_off   (d_off),
        .i_cmd_data  (d_data),
        .o_pop       (q_pop),
        .o_stat      (b_stat),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    // A result leaves through the write-back / emit stage and the output register after its sweep step was issued
    a_out_from_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(b_stat.run, 2))
        else $error("result without a sweep step behind it");

    // The back end takes a new command only between sweeps
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !b_stat.run)
        else $error("command taken during a sweep");

    // The clearing pass after reset produces no results
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.init |-> !o_valid && !q_pop)
        else $error("activity during the clearing pass");

endmodule
